>>> rtl/pol_pkg.sv
// Package for the positional ordered list unit.
// Holds opcode and status codes, controller state type and the command/status structs.
// No dependencies.
package pol_pkg;

	localparam int VAL_W     = 32;
	localparam int POS_W     = 8;
	localparam int OP_W      = 3;
	localparam int ST_W      = 3;
	localparam int CNT_OUT_W = 7;

	localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_INS_END   = 3'd1;
	localparam logic [OP_W-1:0] OP_INS_POS   = 3'd2;
	localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
	localparam logic [OP_W-1:0] OP_DEL_END   = 3'd4;
	localparam logic [OP_W-1:0] OP_DEL_POS   = 3'd5;
	localparam logic [OP_W-1:0] OP_DUMP      = 3'd6;

	localparam logic [ST_W-1:0] ST_OK       = 3'd0;
	localparam logic [ST_W-1:0] ST_EMPTY    = 3'd1;
	localparam logic [ST_W-1:0] ST_BADPOS   = 3'd2;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd3;
	localparam logic [ST_W-1:0] ST_FULL     = 3'd4;

	typedef enum logic {
		S_IDLE,
		S_DUMP
	} state_t;

	typedef enum logic [1:0] {
		LOC_FRONT,
		LOC_END,
		LOC_POS
	} loc_t;

	typedef struct packed {
		logic            ins;
		logic            del;
		loc_t            loc;
		logic            rot;
		logic            dump_clr;
		logic            out_load;
		logic            use_elem;
		logic            last;
		logic [ST_W-1:0] status;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic pos_zero;
		logic ins_pos_ok;
		logic del_pos_ok;
		logic dump_last;
		logic out_free;
	} stat_t;

endpackage

>>> rtl/pol_ctrl.sv
// Controller for the positional ordered list unit: decodes the op, picks the status
// and sequences dumps. Depends on pol_pkg.
module pol_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [pol_pkg::OP_W-1:0]    op,
	input  pol_pkg::stat_t              stat,
	output logic                        in_ready,
	output pol_pkg::cmd_t               cmd,
	output pol_pkg::state_t             state
);

	pol_pkg::state_t state_q;
	pol_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pol_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign state = state_q;

	always_comb begin
		state_nxt = state_q;
		in_ready  = 1'b0;
		cmd       = '0;
		cmd.loc   = pol_pkg::LOC_FRONT;
		cmd.status = pol_pkg::ST_OK;
		case (state_q)
			pol_pkg::S_IDLE: begin
				in_ready = stat.out_free;
				if (in_valid && stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.last     = 1'b1;
					case (op)
						pol_pkg::OP_INS_FRONT, pol_pkg::OP_INS_END: begin
							cmd.loc = (op == pol_pkg::OP_INS_FRONT) ?
								pol_pkg::LOC_FRONT : pol_pkg::LOC_END;
							if (stat.full) cmd.status = pol_pkg::ST_FULL;
							else cmd.ins = 1'b1;
						end
						pol_pkg::OP_INS_POS: begin
							cmd.loc = pol_pkg::LOC_POS;
							if (stat.pos_zero) cmd.status = pol_pkg::ST_BADPOS;
							else if (stat.full) cmd.status = pol_pkg::ST_FULL;
							else if (!stat.ins_pos_ok) cmd.status = pol_pkg::ST_NOTFOUND;
							else cmd.ins = 1'b1;
						end
						pol_pkg::OP_DEL_FRONT, pol_pkg::OP_DEL_END: begin
							cmd.loc = (op == pol_pkg::OP_DEL_FRONT) ?
								pol_pkg::LOC_FRONT : pol_pkg::LOC_END;
							if (stat.empty) cmd.status = pol_pkg::ST_EMPTY;
							else cmd.del = 1'b1;
						end
						pol_pkg::OP_DEL_POS: begin
							cmd.loc = pol_pkg::LOC_POS;
							if (stat.empty) cmd.status = pol_pkg::ST_EMPTY;
							else if (stat.pos_zero) cmd.status = pol_pkg::ST_BADPOS;
							else if (!stat.del_pos_ok) cmd.status = pol_pkg::ST_NOTFOUND;
							else cmd.del = 1'b1;
						end
						pol_pkg::OP_DUMP: begin
							if (stat.empty) begin
								cmd.status = pol_pkg::ST_EMPTY;
							end else begin
								// hold the result until the dump sequence emits elements
								cmd.out_load = 1'b0;
								cmd.last     = 1'b0;
								cmd.dump_clr = 1'b1;
								state_nxt    = pol_pkg::S_DUMP;
							end
						end
						default: begin
							cmd.status = pol_pkg::ST_OK;
						end
					endcase
				end
			end
			pol_pkg::S_DUMP: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.use_elem = 1'b1;
					cmd.rot      = 1'b1;
					cmd.last     = stat.dump_last;
					if (stat.dump_last) state_nxt = pol_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = pol_pkg::S_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/pol_dpath.sv
// Datapath for the positional ordered list unit: shifting cell store, element count,
// dump counter and the output word register. Depends on pol_pkg.
module pol_dpath #(
	parameter int DEPTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic signed [pol_pkg::VAL_W-1:0]   value,
	input  logic [pol_pkg::POS_W-1:0]          position,
	input  logic                               out_ready,
	input  pol_pkg::cmd_t                      cmd,
	output pol_pkg::stat_t                     stat,
	output logic                               out_valid,
	output logic [pol_pkg::ST_W-1:0]           status,
	output logic signed [pol_pkg::VAL_W-1:0]   element,
	output logic                               last,
	output logic [pol_pkg::CNT_OUT_W-1:0]      count
);

	localparam int CW  = $clog2(DEPTH + 1);
	localparam int IW  = $clog2(DEPTH);
	localparam int PW1 = pol_pkg::POS_W + 1;

	logic signed [pol_pkg::VAL_W-1:0] cells [DEPTH];
	logic [CW-1:0]                    cnt_q;
	logic [CW-1:0]                    cnt_nxt;
	logic [CW-1:0]                    cnt_m1;
	logic [IW-1:0]                    last_idx;
	logic [IW-1:0]                    dump_idx_q;
	logic [IW-1:0]                    idx;
	logic [pol_pkg::POS_W-1:0]        pos_m1;

	logic                             out_vld_q;
	logic [pol_pkg::ST_W-1:0]         status_q;
	logic signed [pol_pkg::VAL_W-1:0] elem_q;
	logic                             last_q;
	logic [pol_pkg::CNT_OUT_W-1:0]    count_q;

	assign cnt_m1   = cnt_q - 1'b1;
	assign last_idx = cnt_m1[IW-1:0];
	assign pos_m1   = position - 1'b1;

	assign stat.empty      = (cnt_q == '0);
	assign stat.full       = (cnt_q == CW'(DEPTH));
	assign stat.pos_zero   = (position == '0);
	assign stat.ins_pos_ok = ({1'b0, position} <= (PW1'(cnt_q) + PW1'(1)));
	assign stat.del_pos_ok = ({1'b0, position} <= PW1'(cnt_q));
	assign stat.dump_last  = (dump_idx_q == last_idx);
	assign stat.out_free   = !out_vld_q || out_ready;

	always_comb begin
		case (cmd.loc)
			pol_pkg::LOC_FRONT: idx = '0;
			pol_pkg::LOC_END:   idx = cmd.del ? last_idx : cnt_q[IW-1:0];
			pol_pkg::LOC_POS:   idx = pos_m1[IW-1:0];
			default:            idx = '0;
		endcase
	end

	// Shift: below past idx on insert, above from idx on delete, above on rotate.
	for (genvar j = 0; j < DEPTH; j++) begin : g_cell
		logic signed [pol_pkg::VAL_W-1:0] below;
		logic signed [pol_pkg::VAL_W-1:0] above;

		if (j == 0) begin : g_bot
			assign below = cells[j];
		end else begin : g_mid_b
			assign below = cells[j-1];
		end
		if (j == DEPTH - 1) begin : g_top
			assign above = cells[j];
		end else begin : g_mid_a
			assign above = cells[j+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.ins) begin
				if (IW'(j) == idx) cells[j] <= value;
				else if (IW'(j) > idx) cells[j] <= below;
			end else if (cmd.del) begin
				if (IW'(j) >= idx) cells[j] <= above;
			end else if (cmd.rot) begin
				// front word wraps to the tail so the list is whole after the dump
				if (IW'(j) == last_idx) cells[j] <= cells[0];
				else cells[j] <= above;
			end
		end
	end

	always_comb begin
		cnt_nxt = cnt_q;
		if (cmd.ins) cnt_nxt = cnt_q + 1'b1;
		else if (cmd.del) cnt_nxt = cnt_m1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			dump_idx_q <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			cnt_q <= cnt_nxt;
			if (cmd.dump_clr) dump_idx_q <= '0;
			else if (cmd.rot) dump_idx_q <= dump_idx_q + 1'b1;
			if (cmd.out_load) out_vld_q <= 1'b1;
			else if (out_ready) out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status_q <= cmd.status;
			last_q   <= cmd.last;
			elem_q   <= cmd.use_elem ? cells[0] : '0;
			count_q  <= pol_pkg::CNT_OUT_W'(cnt_nxt);
		end
	end

	assign out_valid = out_vld_q;
	assign status    = status_q;
	assign element   = elem_q;
	assign last      = last_q;
	assign count     = count_q;

endmodule

>>> rtl/positional_ordered_list_unit.sv
// Top level of the positional ordered list unit.
// Instantiates pol_ctrl and pol_dpath; depends on pol_pkg.
//
//   channel | handshake            | words
//   --------+----------------------+------------------------------------------
//   in      | in_valid / in_ready  | op, value, position
//   out     | out_valid / out_ready| status, element, last, count
//
// Insert and delete shift the cell row when the command is taken: one word in, one word
// out per cycle while the output is not stalled. A dump of N held elements takes the
// command, then emits one word per element from the front; the cell row rotates once per
// emitted word and no input is taken until the last element is loaded.
// Reset clears the element count and handshake state; cells are not cleared.
// A stalled output holds its word; a new input is taken when the output register is
// empty or being drained in the same cycle.
module positional_ordered_list_unit #(
	parameter int DEPTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [pol_pkg::OP_W-1:0]           op,
	input  logic signed [pol_pkg::VAL_W-1:0]   value,
	input  logic [pol_pkg::POS_W-1:0]          position,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [pol_pkg::ST_W-1:0]           status,
	output logic signed [pol_pkg::VAL_W-1:0]   element,
	output logic                               last,
	output logic [pol_pkg::CNT_OUT_W-1:0]      count
);

	pol_pkg::cmd_t   cmd;
	pol_pkg::stat_t  stat;
	pol_pkg::state_t state;

	pol_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.op       (op),
		.stat     (stat),
		.in_ready (in_ready),
		.cmd      (cmd),
		.state    (state)
	);

	pol_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (value),
		.position  (position),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.status    (status),
		.element   (element),
		.last      (last),
		.count     (count)
	);

	ap_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (count <= pol_pkg::CNT_OUT_W'(DEPTH)))
		else $error("count beyond depth");

	ap_no_take_in_dump: assert property (@(posedge clk) disable iff (!arst_n)
		(state == pol_pkg::S_DUMP) |-> !in_ready)
		else $error("input taken during dump");

	ap_elem_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != pol_pkg::ST_OK)) |-> (element == '0))
		else $error("nonzero element on error word");

	ap_dump_ends_last: assert property (@(posedge clk) disable iff (!arst_n)
		((state == pol_pkg::S_DUMP) && cmd.out_load && cmd.last) |=> (state == pol_pkg::S_IDLE))
		else $error("dump did not end on last word");

endmodule

>>> sim/tb_positional_ordered_list_unit.sv
`timescale 1ns / 100ps
// Self-checking bench for positional_ordered_list_unit: random and directed list commands,
// with a shadow list that predicts every status, dump element and count.
// Depends on pol_pkg and the unit RTL.
module tb_positional_ordered_list_unit;
	import pol_pkg::*;

	localparam int DEPTH = 16;
	localparam int WORDS_TARGET = 470;
	localparam logic [OP_W-1:0] OP_SPARE = 3'd7;

	typedef struct packed {
		logic [ST_W-1:0]         status;
		logic signed [VAL_W-1:0] element;
		logic                    last;
		logic [CNT_OUT_W-1:0]    count;
	} list_answer_t;

	class list_tracker;
		logic signed [VAL_W-1:0] cells[$];
		list_answer_t answers_due[$];
		int fails;
		int checked;
		int status_seen[5];

		function new();
			fails = 0;
			checked = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		function int held();
			return cells.size();
		endfunction

		function int pending();
			return answers_due.size();
		endfunction

		function void push_answer(logic [ST_W-1:0] st, logic signed [VAL_W-1:0] el, logic lst);
			list_answer_t a;
			a.status  = st;
			a.element = el;
			a.last    = lst;
			a.count   = CNT_OUT_W'(cells.size());
			answers_due.push_back(a);
		endfunction

		function void take_command(logic [OP_W-1:0] o, logic signed [VAL_W-1:0] v,
				logic [POS_W-1:0] p);
			logic [ST_W-1:0] st;
			int n;
			int pi;
			st = ST_OK;
			n  = cells.size();
			pi = int'(p);
			case (o)
				OP_INS_FRONT, OP_INS_END: begin
					if (n >= DEPTH)
						st = ST_FULL;
					else if (o == OP_INS_FRONT)
						cells.push_front(v);
					else
						cells.push_back(v);
				end
				OP_INS_POS: begin
					if (pi == 0)
						st = ST_BADPOS;
					else if (n >= DEPTH)
						st = ST_FULL;
					else if (pi > n + 1)
						st = ST_NOTFOUND;
					else
						cells.insert(pi - 1, v);
				end
				OP_DEL_FRONT, OP_DEL_END: begin
					if (n == 0)
						st = ST_EMPTY;
					else if (o == OP_DEL_FRONT)
						void'(cells.pop_front());
					else
						void'(cells.pop_back());
				end
				OP_DEL_POS: begin
					if (n == 0)
						st = ST_EMPTY;
					else if (pi == 0)
						st = ST_BADPOS;
					else if (pi > n)
						st = ST_NOTFOUND;
					else
						cells.delete(pi - 1);
				end
				OP_DUMP: begin
					if (n == 0) begin
						st = ST_EMPTY;
					end else begin
						foreach (cells[i]) push_answer(ST_OK, cells[i], i == n - 1);
						return;
					end
				end
				default: ;
			endcase
			push_answer(st, '0, 1'b1);
		endfunction

		function void check_word(logic [ST_W-1:0] st, logic signed [VAL_W-1:0] el, logic lst,
				logic [CNT_OUT_W-1:0] cnt);
			list_answer_t want;
			if (answers_due.size() == 0) begin
				$display("%0t: unexpected word: status %0d element %0d last %0d count %0d",
					$time, st, el, lst, cnt);
				fails++;
				return;
			end
			want = answers_due.pop_front();
			checked++;
			if (st < 5) status_seen[st]++;
			if (st !== want.status || el !== want.element || lst !== want.last ||
					cnt !== want.count) begin
				$display("%0t: mismatch: expected status %0d element %0d last %0d count %0d",
					$time, want.status, want.element, want.last, want.count);
				$display("%0t:           actual   status %0d element %0d last %0d count %0d",
					$time, st, el, lst, cnt);
				fails++;
			end
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic [OP_W-1:0]         op;
	logic signed [VAL_W-1:0] value;
	logic [POS_W-1:0]        position;
	logic                    out_valid;
	logic                    out_ready;
	logic [ST_W-1:0]         status;
	logic signed [VAL_W-1:0] element;
	logic                    last;
	logic [CNT_OUT_W-1:0]    count;

	list_tracker sb = new();
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_request = 0;
	int hold_left = 0;
	int words_sent = 0;

	positional_ordered_list_unit #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.value(value),
		.position(position),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.element(element),
		.last(last),
		.count(count)
	);

	always #10 clk = ~clk;

	initial begin
		#10_000_000;
		$display("tb_positional_ordered_list_unit: errors");
		$finish;
	end

	// Receiver: check accepted words, then pick ready for the next cycle.
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_word(status, element, last, count);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Enter at a rising edge; return at the edge where the word was taken, valid still high.
	task automatic offer_word(input logic [OP_W-1:0] o, input logic signed [VAL_W-1:0] v,
			input logic [POS_W-1:0] p);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= o;
		value    <= v;
		position <= p;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.take_command(o, v, p);
		if (o != OP_SPARE) words_sent++;
	endtask

	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(7))
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			2: return '0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	task automatic insert_word();
		int n;
		logic [POS_W-1:0] p;
		n = sb.held();
		p = ($urandom_range(3) == 0) ? POS_W'($urandom_range(255)) : POS_W'($urandom_range(n + 1, 1));
		case ($urandom_range(2))
			0: offer_word(OP_INS_FRONT, pick_value(), POS_W'($urandom_range(255)));
			1: offer_word(OP_INS_END, pick_value(), POS_W'($urandom_range(255)));
			default: offer_word(OP_INS_POS, pick_value(), p);
		endcase
	endtask

	task automatic delete_word();
		int n;
		logic [POS_W-1:0] p;
		n = sb.held();
		p = ($urandom_range(4) == 0) ? POS_W'($urandom_range(255))
			: POS_W'($urandom_range((n > 0) ? n : 1, 1));
		case ($urandom_range(2))
			0: offer_word(OP_DEL_FRONT, $urandom, POS_W'($urandom_range(255)));
			1: offer_word(OP_DEL_END, $urandom, POS_W'($urandom_range(255)));
			default: offer_word(OP_DEL_POS, $urandom, p);
		endcase
	endtask

	task automatic random_word();
		int r;
		r = $urandom_range(99);
		if (r < 45)
			insert_word();
		else if (r < 80)
			delete_word();
		else if (r < 95)
			offer_word(OP_DUMP, $urandom, POS_W'($urandom_range(255)));
		else
			offer_word(OP_SPARE, $urandom, POS_W'($urandom_range(255)));
	endtask

	// Fill to capacity, push a couple of inserts against the full list, then dump it.
	task automatic fill_run();
		while (sb.held() < DEPTH) insert_word();
		repeat (2) insert_word();
		offer_word(OP_DUMP, $urandom, '0);
	endtask

	task automatic drain_run();
		while (sb.held() > 0) delete_word();
		repeat (2) delete_word();
	endtask

	task automatic run_mixed(input int upto);
		int r;
		while (words_sent < upto) begin
			r = $urandom_range(9);
			if (r < 2)
				fill_run();
			else if (r < 4)
				drain_run();
			else
				repeat (8) random_word();
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	initial begin
		int guard;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		op       = OP_INS_FRONT;
		value    = '0;
		position = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty-list corner cases, position checks, extremes of value and position.
		offer_word(OP_DUMP, '0, '0);
		offer_word(OP_DEL_FRONT, '0, '0);
		offer_word(OP_DEL_END, '0, '0);
		offer_word(OP_DEL_POS, '0, 8'd0);
		offer_word(OP_DEL_POS, '0, 8'd255);
		offer_word(OP_INS_POS, 32'sd5, 8'd0);
		offer_word(OP_INS_POS, 32'sd6, 8'd2);
		offer_word(OP_INS_FRONT, 32'sh7FFF_FFFF, 8'd0);
		offer_word(OP_INS_END, 32'sh8000_0000, 8'd255);
		offer_word(OP_INS_POS, -32'sd1, 8'd1);
		offer_word(OP_INS_POS, 32'sd0, 8'd4);
		offer_word(OP_INS_POS, 32'sh5555_5555, 8'd3);
		offer_word(OP_INS_POS, 32'sd7, 8'd7);
		offer_word(OP_INS_POS, 32'shAAAA_AAAA, 8'd255);
		offer_word(OP_DUMP, '0, '0);
		offer_word(OP_SPARE, $urandom, 8'hFF);
		offer_word(OP_DEL_POS, '0, 8'd0);
		offer_word(OP_DEL_POS, '0, 8'd6);
		offer_word(OP_DEL_POS, '0, 8'd3);
		offer_word(OP_DEL_FRONT, '0, '0);
		offer_word(OP_DEL_END, '0, '0);
		offer_word(OP_DUMP, '0, '0);
		offer_word(OP_DEL_POS, '0, 8'd2);
		offer_word(OP_DEL_POS, '0, 8'd1);
		offer_word(OP_DUMP, '0, '0);

		send_idle_pct = 19;
		recv_idle_pct = 59;
		fill_run();
		run_mixed(170);

		// Stall the output for a long stretch while words keep coming.
		send_idle_pct = 0;
		hold_request = 80;
		fill_run();
		repeat (10) random_word();
		wait_drained();

		send_idle_pct = 59;
		recv_idle_pct = 19;
		run_mixed(320);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_mixed(WORDS_TARGET);
		in_valid <= 1'b0;

		guard = 0;
		while (sb.pending() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (DEPTH + 10) @(posedge clk);
		if (sb.pending() != 0) begin
			$display("%0t: %0d expected words never arrived", $time, sb.pending());
			sb.fails++;
		end

		$display("Sent %0d commands, checked %0d result words.", words_sent, sb.checked);
		$display("Statuses seen: ok %0d, empty %0d, bad position %0d, not found %0d, full %0d.",
			sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3],
			sb.status_seen[4]);
		if (sb.fails == 0)
			$display("tb_positional_ordered_list_unit: clean");
		else
			$display("tb_positional_ordered_list_unit: errors");
		$finish;
	end
endmodule
